// ===== rtl/nsd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_pkg
// shared widths, register map, microcode fields and control store of the
// noise shaping filter / decimator
// ----------------------------------------------------------------------------
package nsd_pkg;

	localparam int SAMPLE_W = 24;
	localparam int STATE_W  = 40;
	localparam int FRAC_W   = 24;
	// samples sit one bit below the state fraction point (sample width up to 25)
	localparam int Q_SHIFT  = 25 - SAMPLE_W;
	localparam int SUM_W    = STATE_W + 2;

	localparam int MODE_W  = 3;
	localparam int G_W     = 32;
	localparam int K_W     = 26;
	localparam int DN_W    = 25;
	localparam int STEP_W  = 33;
	localparam int PHASE_W = 32;
	localparam int COEF_W  = 33;

	// multiplier takes the operand magnitude in two halves
	localparam int HALF_W = STATE_W / 2;
	localparam int HI_W   = STATE_W - HALF_W;
	localparam int PP_W   = HI_W + COEF_W;
	localparam int PROD_W = STATE_W + COEF_W;

	localparam int DATA_W = 64;
	localparam int ADDR_W = 6;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [IDX_W-1:0] REG_G     = 3'd1;
	localparam logic [IDX_W-1:0] REG_K     = 3'd2;
	localparam logic [IDX_W-1:0] REG_DN    = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP  = 3'd4;

	localparam logic [MODE_W-1:0] MODE_WHITE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOW   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HIGH  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PEAK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DECIM = 3'd4;

	localparam logic [G_W-1:0]    G_RESET    = 32'd0;
	localparam logic [K_W-1:0]    K_RESET    = 26'd30198989;
	localparam logic [DN_W-1:0]   DN_RESET   = 25'd16777216;
	localparam logic [STEP_W-1:0] STEP_RESET = 33'h1_0000_0000;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_START = 4'd0;
	localparam pc_t PC_PASS  = 4'd13;

	typedef enum logic [1:0] {MUL_NONE, MUL_LO, MUL_HI} mul_op_t;
	typedef enum logic [1:0] {MA_S1, MA_T, MA_HP, MA_BP} mul_a_t;
	typedef enum logic [1:0] {MB_GK, MB_DN, MB_G} mul_b_t;
	typedef enum logic [2:0] {
		SRC_ZERO, SRC_X, SRC_S1, SRC_S2, SRC_T, SRC_LP, SRC_BP, SRC_MUL
	} src_t;
	typedef enum logic [2:0] {
		DST_NONE, DST_T, DST_HP, DST_BP, DST_S1, DST_LP, DST_S2
	} dst_t;
	typedef enum logic [1:0] {OUT_NONE, OUT_FILT, OUT_DIRECT} out_sel_t;

	typedef struct packed {
		mul_op_t  mul_op;
		mul_a_t   mul_a;
		mul_b_t   mul_b;
		src_t     alu_a;
		src_t     alu_b;
		logic     neg_b;
		src_t     alu_c;
		logic     neg_c;
		dst_t     dst;
		logic     ld_t_mul;
		out_sel_t out_sel;
		logic     jmp_nf;
		pc_t      jmp_to;
		logic     last;
	} ctl_t;

	// control store
	function automatic ctl_t rom(input pc_t pc);
		ctl_t c;
		c.mul_op   = MUL_NONE;
		c.mul_a    = MA_S1;
		c.mul_b    = MB_GK;
		c.alu_a    = SRC_ZERO;
		c.alu_b    = SRC_ZERO;
		c.neg_b    = 1'b0;
		c.alu_c    = SRC_ZERO;
		c.neg_c    = 1'b0;
		c.dst      = DST_NONE;
		c.ld_t_mul = 1'b0;
		c.out_sel  = OUT_NONE;
		c.jmp_nf   = 1'b0;
		c.jmp_to   = PC_START;
		c.last     = 1'b0;
		unique case (pc)
			4'd0: begin
				// s1 * (g + k); leave for the direct path outside filter modes
				c.mul_op = MUL_LO;
				c.jmp_nf = 1'b1;
				c.jmp_to = PC_PASS;
			end
			4'd1: begin
				c.mul_op = MUL_HI;
			end
			4'd2: begin
				// u = x - s1*(g+k) - s2
				c.alu_a = SRC_X;
				c.alu_b = SRC_MUL;
				c.neg_b = 1'b1;
				c.alu_c = SRC_S2;
				c.neg_c = 1'b1;
				c.dst   = DST_T;
			end
			4'd3: begin
				c.mul_op = MUL_LO;
				c.mul_a  = MA_T;
				c.mul_b  = MB_DN;
			end
			4'd4: begin
				c.mul_op = MUL_HI;
				c.mul_a  = MA_T;
				c.mul_b  = MB_DN;
			end
			4'd5: begin
				c.alu_a = SRC_MUL;
				c.dst   = DST_HP;
			end
			4'd6: begin
				c.mul_op = MUL_LO;
				c.mul_a  = MA_HP;
				c.mul_b  = MB_G;
			end
			4'd7: begin
				c.mul_op = MUL_HI;
				c.mul_a  = MA_HP;
				c.mul_b  = MB_G;
			end
			4'd8: begin
				// bp = v1 + s1, keep v1 in t
				c.alu_a    = SRC_MUL;
				c.alu_b    = SRC_S1;
				c.dst      = DST_BP;
				c.ld_t_mul = 1'b1;
			end
			4'd9: begin
				c.alu_a  = SRC_T;
				c.alu_b  = SRC_BP;
				c.dst    = DST_S1;
				c.mul_op = MUL_LO;
				c.mul_a  = MA_BP;
				c.mul_b  = MB_G;
			end
			4'd10: begin
				c.mul_op = MUL_HI;
				c.mul_a  = MA_BP;
				c.mul_b  = MB_G;
			end
			4'd11: begin
				// lp = v2 + s2, keep v2 in t
				c.alu_a    = SRC_MUL;
				c.alu_b    = SRC_S2;
				c.dst      = DST_LP;
				c.ld_t_mul = 1'b1;
			end
			4'd12: begin
				c.alu_a   = SRC_T;
				c.alu_b   = SRC_LP;
				c.dst     = DST_S2;
				c.out_sel = OUT_FILT;
				c.last    = 1'b1;
			end
			4'd13: begin
				c.out_sel = OUT_DIRECT;
				c.last    = 1'b1;
			end
			default: begin
			end
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/nsd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsd_datapath
// filter registers, split multiplier, saturating adder, phase accumulator
// and output register, all driven by one control word per cycle when not held
// ----------------------------------------------------------------------------
module nsd_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire nsd_pkg::ctl_t                        ctl,
	input  wire logic                                 adv,
	input  wire logic                                 load_x,
	input  wire logic                                 clr_state,
	input  wire logic signed [nsd_pkg::SAMPLE_W-1:0]  noise_sample,
	input  wire logic [nsd_pkg::MODE_W-1:0]           mode,
	input  wire logic [nsd_pkg::G_W-1:0]              g_coeff,
	input  wire logic [nsd_pkg::K_W-1:0]              k_coeff,
	input  wire logic [nsd_pkg::DN_W-1:0]             damping_norm,
	input  wire logic [nsd_pkg::STEP_W-1:0]           decim_step,
	output logic signed [nsd_pkg::SAMPLE_W-1:0]       out_sample
);

	localparam int SW = nsd_pkg::STATE_W;
	localparam int XW = nsd_pkg::SAMPLE_W;
	localparam int RW = nsd_pkg::PROD_W - nsd_pkg::FRAC_W;

	localparam logic [SW-1:0] ST_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] ST_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [XW-1:0] SMP_MAX = {1'b0, {(XW-1){1'b1}}};
	localparam logic [XW-1:0] SMP_MIN = {1'b1, {(XW-1){1'b0}}};

	function automatic logic [SW-1:0] sat_state(input logic [nsd_pkg::SUM_W-1:0] v);
		logic [nsd_pkg::SUM_W-SW:0] top;
		top = v[nsd_pkg::SUM_W-1:SW-1];
		if (top == '0 || top == '1) begin
			return v[SW-1:0];
		end
		return v[nsd_pkg::SUM_W-1] ? ST_MIN : ST_MAX;
	endfunction

	// floor shift to sample scale, then saturate
	function automatic logic [XW-1:0] to_sample(input logic [SW-1:0] v);
		logic [SW-1:0] sh;
		logic [SW-XW:0] top;
		sh  = SW'($signed(v) >>> nsd_pkg::Q_SHIFT);
		top = sh[SW-1:XW-1];
		if (top == '0 || top == '1) begin
			return sh[XW-1:0];
		end
		return sh[SW-1] ? SMP_MIN : SMP_MAX;
	endfunction

	logic [XW-1:0] x_q;
	logic [SW-1:0] s1_q, s2_q, t_q, hp_q, bp_q, lp_q;
	logic [nsd_pkg::PHASE_W-1:0] phase_q;
	logic [XW-1:0] held_q;
	logic [nsd_pkg::PROD_W-1:0] prod_q;
	logic neg_q;
	logic [XW-1:0] out_q;

	logic [SW-1:0] x_state;
	logic [nsd_pkg::COEF_W-1:0] gk, mul_b_val;
	logic [SW-1:0] mul_src, mag;
	logic [nsd_pkg::HI_W-1:0] half;
	logic [nsd_pkg::PP_W-1:0] pp;
	logic [RW-1:0] r;
	logic big;
	logic [SW-1:0] mul_res;
	logic [SW-1:0] op_a, op_b, op_c;
	logic [nsd_pkg::SUM_W-1:0] ea, eb, ec, sum;
	logic [SW-1:0] alu_res;
	logic [nsd_pkg::PHASE_W+1:0] phase_sum;
	logic capture;
	logic [XW-1:0] filt_out, direct_out;

	assign x_state = {{(SW-XW-nsd_pkg::Q_SHIFT){x_q[XW-1]}}, x_q,
		{nsd_pkg::Q_SHIFT{1'b0}}};
	assign gk = {1'b0, g_coeff} + nsd_pkg::COEF_W'(k_coeff);

	always_comb begin
		unique case (ctl.mul_a)
			nsd_pkg::MA_S1: mul_src = s1_q;
			nsd_pkg::MA_T:  mul_src = t_q;
			nsd_pkg::MA_HP: mul_src = hp_q;
			nsd_pkg::MA_BP: mul_src = bp_q;
			default:        mul_src = s1_q;
		endcase
		unique case (ctl.mul_b)
			nsd_pkg::MB_GK: mul_b_val = gk;
			nsd_pkg::MB_DN: mul_b_val = nsd_pkg::COEF_W'(damping_norm);
			nsd_pkg::MB_G:  mul_b_val = nsd_pkg::COEF_W'(g_coeff);
			default:        mul_b_val = gk;
		endcase
	end

	// magnitude times coefficient, low half then high half
	assign mag  = mul_src[SW-1] ? (~mul_src + 1'b1) : mul_src;
	assign half = (ctl.mul_op == nsd_pkg::MUL_HI) ? mag[SW-1:nsd_pkg::HALF_W]
		: nsd_pkg::HI_W'(mag[nsd_pkg::HALF_W-1:0]);
	assign pp   = nsd_pkg::PP_W'(half) * nsd_pkg::PP_W'(mul_b_val);

	// truncate toward zero, saturate the magnitude, restore the sign
	assign r   = prod_q[nsd_pkg::PROD_W-1:nsd_pkg::FRAC_W];
	assign big = |r[RW-1:SW-1];
	always_comb begin
		if (neg_q) begin
			mul_res = big ? ST_MIN : (~r[SW-1:0] + 1'b1);
		end else begin
			mul_res = big ? ST_MAX : r[SW-1:0];
		end
	end

	function automatic logic [SW-1:0] pick(input nsd_pkg::src_t s,
		input logic [SW-1:0] x, input logic [SW-1:0] s1, input logic [SW-1:0] s2,
		input logic [SW-1:0] t, input logic [SW-1:0] lp, input logic [SW-1:0] bp,
		input logic [SW-1:0] m);
		logic [SW-1:0] v;
		unique case (s)
			nsd_pkg::SRC_ZERO: v = '0;
			nsd_pkg::SRC_X:    v = x;
			nsd_pkg::SRC_S1:   v = s1;
			nsd_pkg::SRC_S2:   v = s2;
			nsd_pkg::SRC_T:    v = t;
			nsd_pkg::SRC_LP:   v = lp;
			nsd_pkg::SRC_BP:   v = bp;
			nsd_pkg::SRC_MUL:  v = m;
			default:           v = '0;
		endcase
		return v;
	endfunction

	assign op_a = pick(ctl.alu_a, x_state, s1_q, s2_q, t_q, lp_q, bp_q, mul_res);
	assign op_b = pick(ctl.alu_b, x_state, s1_q, s2_q, t_q, lp_q, bp_q, mul_res);
	assign op_c = pick(ctl.alu_c, x_state, s1_q, s2_q, t_q, lp_q, bp_q, mul_res);

	assign ea = {{2{op_a[SW-1]}}, op_a};
	assign eb = ctl.neg_b ? (~{{2{op_b[SW-1]}}, op_b} + 1'b1) : {{2{op_b[SW-1]}}, op_b};
	assign ec = ctl.neg_c ? (~{{2{op_c[SW-1]}}, op_c} + 1'b1) : {{2{op_c[SW-1]}}, op_c};
	assign sum = ea + eb + ec;
	assign alu_res = sat_state(sum);

	// phase wraps modulo one, capture whenever the sum reaches one
	assign phase_sum = {2'b00, phase_q} + {1'b0, decim_step};
	assign capture   = |phase_sum[nsd_pkg::PHASE_W+1:nsd_pkg::PHASE_W];

	always_comb begin
		unique case (mode)
			nsd_pkg::MODE_LOW:  filt_out = to_sample(lp_q);
			nsd_pkg::MODE_HIGH: filt_out = to_sample(hp_q);
			default:            filt_out = to_sample(bp_q);
		endcase
		if (mode == nsd_pkg::MODE_DECIM) begin
			direct_out = capture ? x_q : held_q;
		end else begin
			direct_out = x_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q    <= '0;
			s2_q    <= '0;
			phase_q <= '0;
			held_q  <= '0;
		end else if (clr_state) begin
			s1_q    <= '0;
			s2_q    <= '0;
			phase_q <= '0;
			held_q  <= '0;
		end else if (adv) begin
			if (ctl.dst == nsd_pkg::DST_S1) begin
				s1_q <= alu_res;
			end
			if (ctl.dst == nsd_pkg::DST_S2) begin
				s2_q <= alu_res;
			end
			if (ctl.out_sel == nsd_pkg::OUT_DIRECT && mode == nsd_pkg::MODE_DECIM) begin
				phase_q <= phase_sum[nsd_pkg::PHASE_W-1:0];
				if (capture) begin
					held_q <= x_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_x) begin
			x_q <= noise_sample;
		end
		if (adv) begin
			if (ctl.dst == nsd_pkg::DST_T) begin
				t_q <= alu_res;
			end else if (ctl.ld_t_mul) begin
				t_q <= mul_res;
			end
			if (ctl.dst == nsd_pkg::DST_HP) begin
				hp_q <= alu_res;
			end
			if (ctl.dst == nsd_pkg::DST_BP) begin
				bp_q <= alu_res;
			end
			if (ctl.dst == nsd_pkg::DST_LP) begin
				lp_q <= alu_res;
			end
			if (ctl.mul_op == nsd_pkg::MUL_LO) begin
				prod_q <= nsd_pkg::PROD_W'(pp);
				neg_q  <= mul_src[SW-1];
			end else if (ctl.mul_op == nsd_pkg::MUL_HI) begin
				prod_q <= prod_q + (nsd_pkg::PROD_W'(pp) << nsd_pkg::HALF_W);
			end
			if (ctl.out_sel == nsd_pkg::OUT_FILT) begin
				out_q <= filt_out;
			end else if (ctl.out_sel == nsd_pkg::OUT_DIRECT) begin
				out_q <= direct_out;
			end
		end
	end

	assign out_sample = out_q;

endmodule
`default_nettype wire

// ===== rtl/noise_svf_decimator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// noise_svf_decimator_core
// noise shaper: zero-delay state-variable filter, sample-hold decimator or
// passthrough, with coefficients written over an apb-style port
// ----------------------------------------------------------------------------
// A sample runs the whole control store program in lowpass, highpass and
// bandpass modes and only its first word and the direct-path word in white
// and decimate modes, ending as the output register loads. The filter time
// is set by the one 20 x 33 bit multiplier, used twice for each of the four
// dependent products, stepped by a 14-word control store. The next request is
// taken at the edge that finishes the current one, while the finished result
// may still wait in the output register. Coefficients g, k, damping_norm and
// decim_step are computed by software; registers sit at byte addresses 0, 8,
// 16, 24 and 32 with 64-bit data. Writing a different mode clears both
// integrators, the decimator phase and the held sample.
module noise_svf_decimator_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic signed [nsd_pkg::SAMPLE_W-1:0] noise_sample,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	output logic signed [nsd_pkg::SAMPLE_W-1:0]      out_sample,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [nsd_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [nsd_pkg::DATA_W-1:0]          pwdata,
	output logic [nsd_pkg::DATA_W-1:0]               prdata,
	output logic                                     pready
);

	logic [nsd_pkg::MODE_W-1:0] mode_q;
	logic [nsd_pkg::G_W-1:0]    g_coeff_q;
	logic [nsd_pkg::K_W-1:0]    k_coeff_q;
	logic [nsd_pkg::DN_W-1:0]   damping_norm_q;
	logic [nsd_pkg::STEP_W-1:0] decim_step_q;

	logic busy_q;
	nsd_pkg::pc_t pc_q;
	logic result_valid_q;

	nsd_pkg::ctl_t ctl;
	logic [nsd_pkg::IDX_W-1:0] reg_idx;
	logic cfg_wr, clr_state;
	logic is_filter, hold, adv, finish, accept;

	assign pready  = 1'b1;
	assign reg_idx = paddr[nsd_pkg::ADDR_W-1:nsd_pkg::ADDR_W-nsd_pkg::IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign clr_state = cfg_wr && reg_idx == nsd_pkg::REG_MODE
		&& pwdata[nsd_pkg::MODE_W-1:0] != mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= nsd_pkg::MODE_WHITE;
			g_coeff_q      <= nsd_pkg::G_RESET;
			k_coeff_q      <= nsd_pkg::K_RESET;
			damping_norm_q <= nsd_pkg::DN_RESET;
			decim_step_q   <= nsd_pkg::STEP_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				nsd_pkg::REG_MODE: mode_q         <= pwdata[nsd_pkg::MODE_W-1:0];
				nsd_pkg::REG_G:    g_coeff_q      <= pwdata[nsd_pkg::G_W-1:0];
				nsd_pkg::REG_K:    k_coeff_q      <= pwdata[nsd_pkg::K_W-1:0];
				nsd_pkg::REG_DN:   damping_norm_q <= pwdata[nsd_pkg::DN_W-1:0];
				nsd_pkg::REG_STEP: decim_step_q   <= pwdata[nsd_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			nsd_pkg::REG_MODE: prdata = nsd_pkg::DATA_W'(mode_q);
			nsd_pkg::REG_G:    prdata = nsd_pkg::DATA_W'(g_coeff_q);
			nsd_pkg::REG_K:    prdata = nsd_pkg::DATA_W'(k_coeff_q);
			nsd_pkg::REG_DN:   prdata = nsd_pkg::DATA_W'(damping_norm_q);
			nsd_pkg::REG_STEP: prdata = nsd_pkg::DATA_W'(decim_step_q);
			default:           prdata = '0;
		endcase
	end

	// sequencer
	assign ctl = nsd_pkg::rom(pc_q);
	assign is_filter = mode_q == nsd_pkg::MODE_LOW || mode_q == nsd_pkg::MODE_HIGH
		|| mode_q == nsd_pkg::MODE_PEAK;
	// last step waits while the output register is still full and stalled
	assign hold   = ctl.last && result_valid_q && result_stall;
	assign adv    = busy_q && !hold;
	assign finish = adv && ctl.last;
	assign sample_stall = busy_q && !finish;
	assign accept = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			pc_q           <= nsd_pkg::PC_START;
			result_valid_q <= 1'b0;
		end else begin
			if (finish || !busy_q) begin
				busy_q <= accept;
				pc_q   <= nsd_pkg::PC_START;
			end else if (adv) begin
				if (ctl.jmp_nf && !is_filter) begin
					pc_q <= ctl.jmp_to;
				end else begin
					pc_q <= pc_q + 1'b1;
				end
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

	nsd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.adv          (adv),
		.load_x       (accept),
		.clr_state    (clr_state),
		.noise_sample (noise_sample),
		.mode         (mode_q),
		.g_coeff      (g_coeff_q),
		.k_coeff      (k_coeff_q),
		.damping_norm (damping_norm_q),
		.decim_step   (decim_step_q),
		.out_sample   (out_sample)
	);

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= nsd_pkg::PC_PASS)
		else $error("step counter beyond the control store");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && pc_q == nsd_pkg::PC_START)
		else $error("accepted request did not start the program");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result_valid)
		else $error("finished request not presented");

	a_pass_nonfilter: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && pc_q == nsd_pkg::PC_PASS |-> !is_filter)
		else $error("filter mode took the direct path");

endmodule
`default_nettype wire
